/* src/rig_pkg.sv */
package rig_pkg;

   // Block configuration.
   localparam int MAX_RADIX     = 16;
   localparam int INDEX_BITS    = 31;
   localparam int FRACTION_BITS = 32;

   // Fixed field widths of the stream words.
   localparam int SEQ_INDEX_W = 31;
   localparam int RADIX_W     = 5;
   localparam int FRACTION_W  = 32;
   localparam int REQ_DATA_W  = ((SEQ_INDEX_W + RADIX_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((FRACTION_W + 7) / 8) * 8;

   // Derived datapath widths.
   localparam int RAD_LOG = $clog2(MAX_RADIX);
   localparam int SHIFT_W = $clog2(RAD_LOG + 1);
   localparam int RCP_W   = INDEX_BITS + 1;
   localparam int PROD_W  = INDEX_BITS + RCP_W;
   localparam int DEN_W   = INDEX_BITS + RAD_LOG;
   localparam int CNT_W   = $clog2(FRACTION_BITS);
   localparam int TAB_N   = 2 ** RADIX_W;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic dig;
      logic div_init;
      logic div_step;
      logic out_load;
   } rig_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic idx_zero;
   } rig_stat_type;

endpackage

/* src/rig_ctrl.sv */
module rig_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  rig_pkg::rig_stat_type stat,
   output rig_pkg::rig_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CHK  = 5'b00010,
      S_DIG  = 5'b00100,
      S_DIV  = 5'b01000,
      S_DONE = 5'b10000
   } rig_state_type;

   rig_state_type                state_ff, state_in;
   logic [rig_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state, step counter and datapath commands.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.idx_zero) begin
               cmd.div_init = 1'b1;
               cnt_in       = rig_pkg::CNT_W'(rig_pkg::FRACTION_BITS - 1);
               state_in     = S_DIV;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_DIG;
            end
         end
         S_DIG: begin
            cmd.dig  = 1'b1;
            state_in = S_CHK;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The output word stays valid until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* src/rig_dp.sv */
module rig_dp (
   input  logic                                clock,
   input  logic [rig_pkg::SEQ_INDEX_W-1:0]     in_seq_index,
   input  logic [rig_pkg::RADIX_W-1:0]         in_radix,
   input  rig_pkg::rig_cmd_type                cmd,
   output rig_pkg::rig_stat_type               stat,
   output logic [rig_pkg::FRACTION_W-1:0]      out_fraction,
   output logic                                out_bad_radix
);

   localparam int N = rig_pkg::INDEX_BITS;

   logic [rig_pkg::RCP_W-1:0]   recip_tab [rig_pkg::TAB_N];
   logic [rig_pkg::SHIFT_W-1:0] shift_tab [rig_pkg::TAB_N];

   // Reciprocal table: ceil(2^(N+L)/radix) with L = ceil(log2(radix)) gives an
   // exact quotient for every index below 2^N.
   for (genvar g = 0; g < rig_pkg::TAB_N; g++) begin : g_rcp
      localparam int          LG   = (g < 2) ? 0 : $clog2(g);
      localparam logic [63:0] DIVR = 64'((g < 2) ? 1 : g);
      localparam logic [63:0] RCP  = (g >= 2 && g <= rig_pkg::MAX_RADIX) ?
         (((64'd1 << (N + LG)) + DIVR - 64'd1) / DIVR) : 64'd0;
      assign recip_tab[g] = RCP[rig_pkg::RCP_W-1:0];
      assign shift_tab[g] = rig_pkg::SHIFT_W'(LG);
   end

   logic [N-1:0]                     idx_ff;
   logic [rig_pkg::RADIX_W-1:0]      radix_ff;
   logic [rig_pkg::RCP_W-1:0]        recip_ff;
   logic [rig_pkg::SHIFT_W-1:0]      shift_ff;
   logic                             bad_ff;
   logic [rig_pkg::PROD_W-1:0]       prod_ff;
   logic [rig_pkg::DEN_W-1:0]        nmul_ff;
   logic [rig_pkg::DEN_W-1:0]        dmul_ff;
   logic [rig_pkg::DEN_W-1:0]        num_ff;
   logic [rig_pkg::DEN_W-1:0]        den_ff;
   logic [rig_pkg::DEN_W:0]          rem_ff;
   logic [rig_pkg::FRACTION_BITS-1:0] quo_ff;
   logic [rig_pkg::FRACTION_W-1:0]   frac_out_ff;
   logic                             bad_out_ff;

   logic                             bad_in;
   logic [rig_pkg::PROD_W-1:0]       prod_sh;
   logic [N-1:0]                     quot;
   logic [N+rig_pkg::RADIX_W-1:0]    back_mul;
   logic [rig_pkg::RADIX_W-1:0]      digit;
   logic [rig_pkg::DEN_W+rig_pkg::RADIX_W-1:0] nmul_full;
   logic [rig_pkg::DEN_W+rig_pkg::RADIX_W-1:0] dmul_full;
   logic [rig_pkg::DEN_W:0]          rem_sh;
   logic                             rem_ge;

   // Radix range check on the incoming word.
   assign bad_in = (in_radix < rig_pkg::RADIX_W'(2)) ||
                   (32'(in_radix) > rig_pkg::MAX_RADIX);

   // Digit step: quotient from the registered reciprocal product, then digit.
   assign prod_sh  = prod_ff >> shift_ff;
   assign quot     = prod_sh[N +: N];
   assign back_mul = quot * radix_ff;
   assign digit    = rig_pkg::RADIX_W'(idx_ff - back_mul[N-1:0]);

   assign nmul_full = num_ff * radix_ff;
   assign dmul_full = den_ff * radix_ff;

   // Restoring long division step for the fraction bits.
   assign rem_sh = {rem_ff[rig_pkg::DEN_W-1:0], 1'b0};
   assign rem_ge = (rem_sh >= {1'b0, den_ff});

   assign stat.idx_zero = (idx_ff == '0);
   assign out_fraction  = frac_out_ff;
   assign out_bad_radix = bad_out_ff;

   always_ff @(posedge clock) begin
      // Take a new word; a bad radix runs as index zero and yields zero.
      if (cmd.load) begin
         idx_ff   <= bad_in ? '0 : in_seq_index[N-1:0];
         radix_ff <= in_radix;
         recip_ff <= recip_tab[in_radix];
         shift_ff <= shift_tab[in_radix];
         bad_ff   <= bad_in;
         num_ff   <= '0;
         den_ff   <= rig_pkg::DEN_W'(1);
      end
      // First half of a digit: the multiplications.
      if (cmd.mul) begin
         prod_ff <= idx_ff * recip_ff;
         nmul_ff <= nmul_full[rig_pkg::DEN_W-1:0];
         dmul_ff <= dmul_full[rig_pkg::DEN_W-1:0];
      end
      // Second half of a digit: shift the index and append the digit.
      if (cmd.dig) begin
         idx_ff <= quot;
         num_ff <= nmul_ff + rig_pkg::DEN_W'(digit);
         den_ff <= dmul_ff;
      end
      if (cmd.div_init) begin
         rem_ff <= {1'b0, num_ff};
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         quo_ff <= {quo_ff[rig_pkg::FRACTION_BITS-2:0], rem_ge};
      end
      // Output holding register.
      if (cmd.out_load) begin
         frac_out_ff <= rig_pkg::FRACTION_W'(quo_ff);
         bad_out_ff  <= bad_ff;
      end
   end

endmodule

/* src/radical_inverse_generator.sv */
// Radical inverse generator: one coordinate of a Halton point per word.
// Request channel (req_): tdata carries the sequence index and the radix.
// The index's digits in that radix are mirrored behind the radix point and
// the result is returned on the response channel (rsp_) as an unsigned Q0.32
// fraction, truncated; tuser flags a radix below 2 or above 16, in which case
// the fraction is zero. Index zero gives zero.
// Once a word is accepted, a zero check on the index comes before each of
// its radix digits (none for index zero or a bad radix); each digit passes
// through the reciprocal multiply and then the digit update of the shared
// digit unit. When the index is zero, a one-bit-per-cycle long division
// turns numerator over radix power into the 32 fraction bits, and then the
// output register is loaded, which raises rsp_tvalid.
// One word is worked at a time; the next request is taken only once the
// previous result has been loaded into the output register.
// Results wait in an output register: a stalled receiver does not block the
// next request, only the hand-over of the following result and so the
// request after it.
// Synchronous reset returns the controller to idle and drops rsp_tvalid.
module radical_inverse_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: seq_index[30:0], radix[35:31], zero padding.
   input  logic [rig_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0: fraction[31:0].
   output logic [rig_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Fields from bit 0: bad_radix.
   output logic                              rsp_tuser
);

   rig_pkg::rig_cmd_type             cmd;
   rig_pkg::rig_stat_type            stat;
   logic [rig_pkg::FRACTION_W-1:0]   fraction;

   rig_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rig_dp u_dp (
      .clock         (clock),
      .in_seq_index  (req_tdata[rig_pkg::SEQ_INDEX_W-1:0]),
      .in_radix      (req_tdata[rig_pkg::SEQ_INDEX_W +: rig_pkg::RADIX_W]),
      .cmd           (cmd),
      .stat          (stat),
      .out_fraction  (fraction),
      .out_bad_radix (rsp_tuser)
   );

   assign rsp_tdata = rig_pkg::RSP_DATA_W'(fraction);

endmodule
